[rtl/bchs_pkg.sv]
`timescale 1ns / 1ps

package bchs_pkg;

	localparam int CFG_W = 8;
	localparam int IN_DW = 8;
	localparam logic [CFG_W-1:0] POLY_RESET = 8'd143;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	typedef struct packed {
		logic rx_bit;
		logic word_end;
	} bchs_item_t;

endpackage

[rtl/bch_syndrome_calculator.sv]
`timescale 1ns / 1ps

// Serial BCH syndrome calculator over GF(2^FIELD_BITS). Takes one received bit per item,
// position 0 first, at one item per cycle while s_axis_tready is high; the item with
// tlast set closes the word and starts a burst of 2*CORRECTABLE syndrome items, S1 first,
// the last one with tlast set. Output items leave at one per cycle while m_axis_tready is
// high, from a snapshot buffer, so the next word streams in during the burst; a word end
// that arrives while a burst is still draining waits in the four-item input queue until
// the burst has room. After reset and after every write of the field polynomial, input is
// held off while the table of alpha powers refills. m_axis_tdata: syndrome index in the
// low bits, then the syndrome value, zero padded to whole bytes.

module bch_syndrome_calculator #(
	parameter int FIELD_BITS  = 8,
	parameter int CORRECTABLE = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [bchs_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bchs_pkg::IN_DW-1:0]       s_axis_tdata,  // [0] received_bit
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// syndrome_index, syndrome_value, zero pad
	output logic [((((2*CORRECTABLE > 1) ? $clog2(2*CORRECTABLE) : 1) + FIELD_BITS + 7)
		/ 8) * 8 - 1:0] m_axis_tdata,
	output logic                             m_axis_tlast
);

	localparam int NS      = 2 * CORRECTABLE;
	localparam int IW      = (NS > 1) ? $clog2(NS) : 1;
	localparam int ODW     = ((IW + FIELD_BITS + 7) / 8) * 8;
	localparam int ENTRIES = FIELD_BITS + NS;

	logic [ENTRIES-1:0][FIELD_BITS-1:0] tbl;
	logic                               tbl_ready;
	bchs_pkg::bchs_item_t               in_item;
	bchs_pkg::bchs_item_t               q_item;
	logic                               q_valid;
	logic                               q_pop;
	logic [IW-1:0]                      syn_index;
	logic [FIELD_BITS-1:0]              syn_value;

	assign in_item.rx_bit   = s_axis_tdata[0];
	assign in_item.word_end = s_axis_tlast;

	bchs_powtab #(
		.FIELD_BITS (FIELD_BITS),
		.CORRECTABLE(CORRECTABLE)
	) u_powtab (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.tbl      (tbl),
		.tbl_ready(tbl_ready)
	);

	bchs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tbl_ready(tbl_ready),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	bchs_back #(
		.FIELD_BITS (FIELD_BITS),
		.CORRECTABLE(CORRECTABLE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tbl      (tbl),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_index(syn_index),
		.out_value(syn_value),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tdata = ODW'({syn_value, syn_index});

endmodule

[rtl/bchs_powtab.sv]
`timescale 1ns / 1ps

module bchs_powtab #(
	parameter int FIELD_BITS  = 8,
	parameter int CORRECTABLE = 6
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 cfg_wen,
	input  logic [bchs_pkg::CFG_W-1:0]                           cfg_wdata,
	output logic [FIELD_BITS+2*CORRECTABLE-1:0][FIELD_BITS-1:0] tbl,
	output logic                                                 tbl_ready
);

	localparam int ENTRIES = FIELD_BITS + 2 * CORRECTABLE;
	localparam int CW      = $clog2(ENTRIES);
	localparam logic [CW-1:0] SETTLE = CW'(ENTRIES - 1);

	logic [FIELD_BITS+bchs_pkg::CFG_W-1:0] wdata_ext;
	logic [FIELD_BITS+bchs_pkg::CFG_W-1:0] reset_ext;
	logic [FIELD_BITS-1:0]                 poly_q;
	logic [ENTRIES-1:0][FIELD_BITS-1:0]    tbl_q;
	logic [CW-1:0]                         settle_q;

	function automatic logic [FIELD_BITS-1:0] times_alpha(
		input logic [FIELD_BITS-1:0] v,
		input logic [FIELD_BITS-1:0] poly
	);
		logic [FIELD_BITS-1:0] r;
		r = {v[FIELD_BITS-2:0], 1'b0};
		if (v[FIELD_BITS-1]) begin
			r = r ^ poly;
		end
		return r;
	endfunction

	assign wdata_ext = {{FIELD_BITS{1'b0}}, cfg_wdata};
	assign reset_ext = {{FIELD_BITS{1'b0}}, bchs_pkg::POLY_RESET};

	// hold field polynomial, restart table settle on every write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q   <= reset_ext[FIELD_BITS-1:0];
			settle_q <= SETTLE;
		end else if (cfg_wen) begin
			poly_q   <= wdata_ext[FIELD_BITS-1:0];
			settle_q <= SETTLE;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// power chain: entry e holds alpha^e, one reduction step per entry
	always_ff @(posedge clk) begin
		tbl_q[0] <= FIELD_BITS'(1);
		for (int e = 1; e < ENTRIES; e++) begin
			tbl_q[e] <= times_alpha(tbl[e-1], poly_q);
		end
	end

	always_comb begin
		tbl    = tbl_q;
		tbl[0] = FIELD_BITS'(1);
	end

	assign tbl_ready = (settle_q == '0);

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> !tbl_ready)
		else $error("power table reported ready right after a polynomial write");

endmodule

[rtl/bchs_front.sv]
`timescale 1ns / 1ps

module bchs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tbl_ready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bchs_pkg::bchs_item_t in_item,
	output logic                 q_valid,
	output bchs_pkg::bchs_item_t q_item,
	input  logic                 q_pop
);

	bchs_pkg::bchs_item_t        mem_q [bchs_pkg::QDEPTH];
	logic [bchs_pkg::QAW-1:0]    wr_ptr_q;
	logic [bchs_pkg::QAW-1:0]    rd_ptr_q;
	logic [bchs_pkg::QCW-1:0]    cnt_q;
	logic                        full;
	logic                        push;

	assign full     = (cnt_q == bchs_pkg::QCW'(bchs_pkg::QDEPTH));
	assign in_ready = !full && tbl_ready;
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bchs_pkg::QCW'(bchs_pkg::QDEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("queue count did not drop on pop");

endmodule

[rtl/bchs_back.sv]
`timescale 1ns / 1ps

module bchs_back #(
	parameter int FIELD_BITS  = 8,
	parameter int CORRECTABLE = 6
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic [FIELD_BITS+2*CORRECTABLE-1:0][FIELD_BITS-1:0] tbl,
	input  logic                                                 q_valid,
	input  bchs_pkg::bchs_item_t                                 q_item,
	output logic                                                 q_pop,
	output logic                                                 out_valid,
	input  logic                                                 out_ready,
	output logic [((2*CORRECTABLE > 1) ? $clog2(2*CORRECTABLE) : 1)-1:0] out_index,
	output logic [FIELD_BITS-1:0]                                out_value,
	output logic                                                 out_last
);

	localparam int NS = 2 * CORRECTABLE;
	localparam int IW = (NS > 1) ? $clog2(NS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NS - 1);

	logic [NS-1:0][FIELD_BITS-1:0] acc_q;
	logic [NS-1:0][FIELD_BITS-1:0] pow_q;
	logic [NS-1:0][FIELD_BITS-1:0] acc_upd;
	logic [NS-1:0][FIELD_BITS-1:0] pow_upd;
	logic [NS-1:0][FIELD_BITS-1:0] out_q;
	logic                          busy_q;
	logic [IW-1:0]                 idx_q;
	logic                          out_hs;
	logic                          buf_free;
	logic                          word_done;

	// each lane: absorb bit, then multiply its running power by alpha^(k+1)
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			acc_upd[k] = acc_q[k] ^ (q_item.rx_bit ? pow_q[k] : '0);
			pow_upd[k] = '0;
			for (int i = 0; i < FIELD_BITS; i++) begin
				if (pow_q[k][i]) begin
					pow_upd[k] = pow_upd[k] ^ tbl[i+k+1];
				end
			end
		end
	end

	assign out_hs    = busy_q && out_ready;
	assign buf_free  = !busy_q || (out_ready && (idx_q == LAST_IDX));
	assign q_pop     = q_valid && (!q_item.word_end || buf_free);
	assign word_done = q_pop && q_item.word_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				acc_q[k] <= '0;
				pow_q[k] <= FIELD_BITS'(1);
			end
		end else if (q_pop) begin
			for (int k = 0; k < NS; k++) begin
				if (q_item.word_end) begin
					acc_q[k] <= '0;
					pow_q[k] <= FIELD_BITS'(1);
				end else begin
					acc_q[k] <= acc_upd[k];
					pow_q[k] <= pow_upd[k];
				end
			end
		end
	end

	// snapshot on word end, shift down as items leave
	always_ff @(posedge clk) begin
		if (word_done) begin
			out_q <= acc_upd;
		end else if (out_hs) begin
			for (int k = 0; k < NS - 1; k++) begin
				out_q[k] <= out_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (word_done) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_hs) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign out_valid = busy_q;
	assign out_index = idx_q;
	assign out_value = out_q[0];
	assign out_last  = (idx_q == LAST_IDX);

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= LAST_IDX))
		else $error("syndrome index past last syndrome");

	assert property (@(posedge clk) disable iff (!arst_n)
		word_done |=> (busy_q && idx_q == '0))
		else $error("word end did not start a syndrome burst");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_hs && idx_q != LAST_IDX) |=> busy_q)
		else $error("syndrome burst ended early");

endmodule
